>>> src/cbf_pkg.sv
// Shared constants, types and a helper function for the counting Bloom filter.
package cbf_pkg;

    localparam int IDX_W         = 10;
    localparam int COUNTER_COUNT = 1 << IDX_W;
    localparam int CNT_W         = 8;
    localparam int HASH_CHAIN    = 3;
    localparam int STEP_W        = 2;

    localparam logic [31:0] MIX_MULT  = 32'h5bd1_e995;
    localparam logic [31:0] HASH_SEED = 32'd2018;
    localparam logic [31:0] HASH_LEN  = 32'd4;
    localparam logic [31:0] HASH_H0   = (HASH_SEED ^ HASH_LEN) * MIX_MULT;
    localparam int          SHIFT_K   = 24;
    localparam int          SHIFT_A   = 13;
    localparam int          SHIFT_B   = 15;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_count CNT_MAX = '1;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_count wdata;
        t_idx   raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_UPDATE,
        ST_WRITE,
        ST_DONE
    } t_state;

    function automatic t_count sat_inc(input t_count v);
        return (v == CNT_MAX) ? v : t_count'(v + 1'b1);
    endfunction

endpackage

>>> src/cbf_hash.sv
// Three-stage pipelined MurmurHash2 of one 32-bit word with a fixed seed.
module cbf_hash
    import cbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_word,
    output logic        o_valid,
    output logic [31:0] o_hash
);

    logic [2:0]  r_valid;
    logic [31:0] r_k1;
    logic [31:0] r_k2;
    logic [31:0] r_m;
    logic [31:0] w_kmix;
    logic [31:0] w_h;

    always_comb begin
        w_kmix = r_k1 ^ (r_k1 >> SHIFT_K);
        w_h    = HASH_H0 ^ r_k2;
        w_h    = w_h ^ (w_h >> SHIFT_A);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1 <= i_word * MIX_MULT;
        r_k2 <= w_kmix * MIX_MULT;
        r_m  <= w_h * MIX_MULT;
    end

    assign o_valid = r_valid[2];
    assign o_hash  = r_m ^ (r_m >> SHIFT_B);

endmodule

>>> src/cbf_store.sv
// Counter memory with one write port and one registered read port.
module cbf_store
    import cbf_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_count   o_rdata
);

    t_count r_mem [COUNTER_COUNT];
    t_count r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cbf_ctrl.sv
// Sequencer for hash chaining, counter reads, saturating updates and results.
module cbf_ctrl
    import cbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_opcode,
    input  logic [31:0] i_key,
    output logic        busy,
    output logic        o_valid,
    output logic        o_maybe_present,
    output logic        o_counter_saturated,
    output logic        o_hash_valid,
    output logic [31:0] o_hash_word,
    input  logic        i_hash_valid,
    input  logic [31:0] i_hash,
    output t_mem_req    o_mem_req,
    input  t_count      i_rdata
);

    t_state r_state;
    t_state n_state;
    t_idx   r_clr;
    t_step  r_step;
    logic   r_op;
    t_idx   r_idx [HASH_CHAIN];
    t_count r_val [HASH_CHAIN];
    t_count r_new [HASH_CHAIN];
    logic   r_present;
    logic   r_sat;
    t_count n_eff [HASH_CHAIN];
    t_count n_new [HASH_CHAIN];
    logic   n_present;
    logic   n_sat;

    always_comb begin
        n_eff[0] = r_val[0];
        n_new[0] = sat_inc(n_eff[0]);
        n_eff[1] = (r_idx[1] == r_idx[0]) ? n_new[0] : r_val[1];
        n_new[1] = sat_inc(n_eff[1]);
        if (r_idx[2] == r_idx[1]) begin
            n_eff[2] = n_new[1];
        end else if (r_idx[2] == r_idx[0]) begin
            n_eff[2] = n_new[0];
        end else begin
            n_eff[2] = i_rdata;
        end
        n_new[2]  = sat_inc(n_eff[2]);
        n_present = (r_val[0] != '0) && (r_val[1] != '0) && (i_rdata != '0);
        n_sat     = (n_eff[0] == CNT_MAX) || (n_eff[1] == CNT_MAX) ||
                    (n_eff[2] == CNT_MAX);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == t_idx'(COUNTER_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (start) n_state = ST_HASH;
            ST_HASH:   if (i_hash_valid && r_step == t_step'(HASH_CHAIN - 1)) begin
                n_state = ST_READ;
            end
            ST_READ:   if (r_step == t_step'(HASH_CHAIN - 1)) n_state = ST_UPDATE;
            ST_UPDATE: n_state = (r_op == OP_INSERT) ? ST_WRITE : ST_DONE;
            ST_WRITE:  if (r_step == t_step'(HASH_CHAIN - 1)) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy                = (r_state != ST_IDLE);
        o_valid             = (r_state == ST_DONE);
        o_maybe_present     = (r_state == ST_DONE) && r_present;
        o_counter_saturated = (r_state == ST_DONE) && r_sat;
        o_hash_valid        = 1'b0;
        o_hash_word         = i_hash;
        o_mem_req.we        = 1'b0;
        o_mem_req.waddr     = r_idx[r_step];
        o_mem_req.wdata     = r_new[r_step];
        o_mem_req.raddr     = r_idx[r_step];
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = '0;
            end
            ST_IDLE: begin
                o_hash_valid = start;
                o_hash_word  = i_key;
            end
            ST_HASH: begin
                o_hash_valid = i_hash_valid && (r_step != t_step'(HASH_CHAIN - 1));
            end
            ST_WRITE: begin
                o_mem_req.we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= t_idx'(r_clr + 1'b1);
            end
            unique case (r_state)
                ST_HASH: if (i_hash_valid) begin
                    r_step <= (r_step == t_step'(HASH_CHAIN - 1)) ? '0
                                                                  : t_step'(r_step + 1'b1);
                end
                ST_READ, ST_WRITE: begin
                    r_step <= (r_step == t_step'(HASH_CHAIN - 1)) ? '0
                                                                  : t_step'(r_step + 1'b1);
                end
                default: r_step <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_op <= i_opcode;
        end
        if (r_state == ST_HASH && i_hash_valid) begin
            r_idx[r_step] <= i_hash[IDX_W-1:0];
        end
        if (r_state == ST_READ && r_step != '0) begin
            r_val[r_step - 1'b1] <= i_rdata;
        end
        if (r_state == ST_UPDATE) begin
            r_new[0]  <= n_new[0];
            r_new[1]  <= n_new[1];
            r_new[2]  <= n_new[2];
            r_present <= n_present;
            r_sat     <= n_sat && (r_op == OP_INSERT);
        end
    end

endmodule

>>> src/counting_bloom_filter_murmur.sv
// Top level of the counting Bloom filter with chained MurmurHash2 indexing.
//
// Usage: present an item on i_opcode and i_key with start high. The item is
// accepted at a rising edge where start is high and busy is low. Opcode 0
// inserts the key, opcode 1 queries it. Each item gives one result, shown on
// o_maybe_present and o_counter_saturated for exactly one cycle while o_valid
// is high; the receiver cannot stall and must take it in that cycle.
// Busy stays high from acceptance until the result, so no new item is taken
// before the result; the next item can be accepted in the cycle after it.
// An item runs three chained hashes through one three-stage multiply
// pipeline, then the counter reads, the update, for an insert three writes
// through the single counter memory port, and the result cycle.
// Reset is synchronous and active low. After reset a clearing pass zeroes the
// 1024 counters, one per cycle, and busy stays high until the pass is done.
module counting_bloom_filter_murmur
    import cbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_opcode,
    input  logic [31:0] i_key,
    output logic        busy,
    output logic        o_valid,
    output logic        o_maybe_present,
    output logic        o_counter_saturated
);

    logic        w_hin_valid;
    logic [31:0] w_hin_word;
    logic        w_hout_valid;
    logic [31:0] w_hout;
    t_mem_req    w_req;
    t_count      w_rdata;

    cbf_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hin_valid),
        .i_word  (w_hin_word),
        .o_valid (w_hout_valid),
        .o_hash  (w_hout)
    );

    cbf_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    cbf_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .i_opcode            (i_opcode),
        .i_key               (i_key),
        .busy                (busy),
        .o_valid             (o_valid),
        .o_maybe_present     (o_maybe_present),
        .o_counter_saturated (o_counter_saturated),
        .o_hash_valid        (w_hin_valid),
        .o_hash_word         (w_hin_word),
        .i_hash_valid        (w_hout_valid),
        .i_hash              (w_hout),
        .o_mem_req           (w_req),
        .i_rdata             (w_rdata)
    );

endmodule

>>> src/cbf_checker.sv
// Port-level checks for the counting Bloom filter and their bind statement.
module cbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_maybe_present,
    input logic        o_counter_saturated
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while the block was idle");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_sat_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_counter_saturated || o_maybe_present) |-> o_valid)
        else $error("result field active without the strobe");

endmodule

bind counting_bloom_filter_murmur cbf_checker u_cbf_checker (.*);

>>> tb/counting_bloom_filter_murmur_tb.sv
// Self-checking testbench for the counting Bloom filter with chained MurmurHash2 indexing.
`timescale 1ns / 1ps

module counting_bloom_filter_murmur_tb;
    import cbf_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int SETTLE_CYCLES = 40;

    typedef t_idx [HASH_CHAIN-1:0] t_slots;

    typedef struct packed {
        logic maybe_present;
        logic counter_saturated;
    } t_filter_result;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key;
        logic        drain;
    } t_filter_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_opcode = OP_INSERT;
    logic [31:0] i_key = '0;
    logic        busy;
    logic        o_valid;
    logic        o_maybe_present;
    logic        o_counter_saturated;

    t_filter_item   item_q[$];
    t_filter_result result_q[$];
    t_count         filter_counts[COUNTER_COUNT] = '{default: '0};
    int             error_count = 0;
    int             cycle_count = 0;
    int             issued_count = 0;
    int             gap_left = 0;

    counting_bloom_filter_murmur DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_opcode           (i_opcode),
        .i_key              (i_key),
        .busy               (busy),
        .o_valid            (o_valid),
        .o_maybe_present    (o_maybe_present),
        .o_counter_saturated(o_counter_saturated)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [31:0] murmur_word(input logic [31:0] word);
        logic [31:0] k;
        logic [31:0] h;
        k = word * MIX_MULT;
        k = k ^ (k >> SHIFT_K);
        k = k * MIX_MULT;
        h = (HASH_SEED ^ HASH_LEN) * MIX_MULT;
        h = h ^ k;
        h = h ^ (h >> SHIFT_A);
        h = h * MIX_MULT;
        h = h ^ (h >> SHIFT_B);
        return h;
    endfunction

    function automatic t_slots filter_slots(input logic [31:0] key);
        t_slots      slots;
        logic [31:0] h;
        h = key;
        for (int i = 0; i < HASH_CHAIN; i++) begin
            h = murmur_word(h);
            slots[i] = t_idx'(h % 32'(COUNTER_COUNT));
        end
        return slots;
    endfunction

    task automatic predict_filter_result(input logic opcode, input logic [31:0] key);
        t_slots         slots;
        t_filter_result res;
        slots = filter_slots(key);
        res.maybe_present = 1'b1;
        res.counter_saturated = 1'b0;
        for (int i = 0; i < HASH_CHAIN; i++) begin
            if (filter_counts[slots[i]] == '0) begin
                res.maybe_present = 1'b0;
            end
        end
        if (opcode == OP_INSERT) begin
            for (int i = 0; i < HASH_CHAIN; i++) begin
                if (filter_counts[slots[i]] == CNT_MAX) begin
                    res.counter_saturated = 1'b1;
                end else begin
                    filter_counts[slots[i]] = filter_counts[slots[i]] + 1'b1;
                end
            end
        end
        result_q.push_back(res);
    endtask

    task automatic queue_item(input logic opcode, input logic [31:0] key, input logic drain);
        t_filter_item it;
        it.opcode = opcode;
        it.key = key;
        it.drain = drain;
        item_q.push_back(it);
    endtask

    always @(posedge i_clk) begin
        t_filter_item nxt;
        logic         gap_phase;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else if (!(start && busy)) begin
            if (start) begin
                predict_filter_result(i_opcode, i_key);
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (item_q.size() > 0 &&
                         (!item_q[0].drain || (!start && result_q.size() == 0))) begin
                nxt = item_q.pop_front();
                i_opcode <= nxt.opcode;
                i_key <= nxt.key;
                start <= 1'b1;
                issued_count++;
                gap_phase = ((issued_count / 100) % 2) == 0;
                if (item_q.size() > 120 && gap_phase && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(1, 19);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_filter_result want;
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual present=%0b saturated=%0b",
                         $time, o_maybe_present, o_counter_saturated);
                error_count++;
            end else begin
                want = result_q.pop_front();
                if (o_maybe_present !== want.maybe_present) begin
                    $display("%0t: maybe_present mismatch: expected %0b, actual %0b",
                             $time, want.maybe_present, o_maybe_present);
                    error_count++;
                end
                if (o_counter_saturated !== want.counter_saturated) begin
                    $display("%0t: counter_saturated mismatch: expected %0b, actual %0b",
                             $time, want.counter_saturated, o_counter_saturated);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [31:0] dup_key;
        logic [31:0] hot_keys[3];
        logic [31:0] seen_keys[$];
        logic [31:0] key;
        t_slots      slots;
        int          pick;
        logic        timed_out;

        timed_out = 1'b0;
        dup_key = 32'h1;
        for (int n = 1; n < 200000; n++) begin
            slots = filter_slots(n);
            if (slots[0] == slots[1] || slots[1] == slots[2] || slots[0] == slots[2]) begin
                dup_key = n;
                break;
            end
        end

        queue_item(OP_QUERY, 32'h0000_0000, 1'b0);
        queue_item(OP_INSERT, 32'h0000_0000, 1'b0);
        queue_item(OP_QUERY, 32'h0000_0000, 1'b0);
        queue_item(OP_QUERY, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_QUERY, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_QUERY, 32'h5555_5555, 1'b0);
        queue_item(OP_INSERT, 32'hAAAA_AAAA, 1'b0);
        queue_item(OP_QUERY, 32'hAAAA_AAAA, 1'b0);
        queue_item(OP_INSERT, dup_key, 1'b0);
        queue_item(OP_INSERT, dup_key, 1'b0);
        queue_item(OP_QUERY, dup_key, 1'b0);
        queue_item(OP_INSERT, 32'h8000_0000, 1'b0);
        queue_item(OP_INSERT, 32'h0000_0001, 1'b0);
        queue_item(OP_QUERY, 32'h0000_0001, 1'b0);

        // A few hot keys are inserted hundreds of times so their counters saturate.
        hot_keys[0] = dup_key;
        hot_keys[1] = $urandom;
        hot_keys[2] = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                queue_item(OP_INSERT, hot_keys[$urandom_range(0, 2)], n == 0 || n == 975);
            end else if (pick < 55) begin
                queue_item(OP_QUERY, hot_keys[$urandom_range(0, 2)], n == 0 || n == 975);
            end else if (pick < 70 && seen_keys.size() > 0) begin
                key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
                queue_item(1'($urandom_range(0, 1)), key, n == 0 || n == 975);
            end else begin
                key = $urandom;
                if ($urandom_range(0, 1) == 0) begin
                    seen_keys.push_back(key);
                    queue_item(OP_INSERT, key, n == 0 || n == 975);
                end else begin
                    queue_item(OP_QUERY, key, n == 0 || n == 975);
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                wait (item_q.size() == 0 && !start);
                wait (result_q.size() == 0);
                repeat (SETTLE_CYCLES) @(posedge i_clk);
            end
            begin
                wait (cycle_count >= RUN_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (timed_out || error_count != 0) begin
            $display("== FAIL ==");
        end else begin
            $display("== PASS ==");
        end
        $finish;
    end

endmodule
